// ----- hdl/sxt_pkg.sv -----
package sxt_pkg;

  // Field widths
  localparam int ACTION_W = 3;
  localparam int IDX_W    = 4;
  localparam int ADDR_W   = 32;
  localparam int VALUE_W  = 33;
  localparam int COUNT_W  = 5;

  // Entries that an entry_index can reach
  localparam int TABLE_CAP = 2 ** IDX_W;

  // Command queue depth and pointer width
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Register map
  localparam logic [1:0] CFG_COUNT_ADDR = 2'd0;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_V2F   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_V2REL = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_F2V   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_V2IDX = 3'd4;

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_WRITE,
    JOB_LOOKUP
  } job_kind_t;

  // Input transaction
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [IDX_W-1:0]    entry_index;
    logic [ADDR_W-1:0]   virt_start;
    logic [ADDR_W-1:0]   virt_size;
    logic [ADDR_W-1:0]   raw_start;
    logic [ADDR_W-1:0]   raw_size;
    logic [ADDR_W-1:0]   query_addr;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   section_index;
    logic [VALUE_W-1:0] value;
  } res_t;

  // One section table entry
  typedef struct packed {
    logic [ADDR_W-1:0] vs;
    logic [ADDR_W-1:0] vsz;
    logic [ADDR_W-1:0] rs;
    logic [ADDR_W-1:0] rsz;
  } entry_t;

  // Classified job held in the queue
  typedef struct packed {
    job_kind_t           kind;
    logic [ACTION_W-1:0] action;
    logic                by_raw;
    logic [IDX_W-1:0]    entry_index;
    entry_t              entry;
    logic [ADDR_W-1:0]   addr;
  } job_t;

endpackage

// ----- hdl/sxt_front.sv -----
module sxt_front
  import sxt_pkg::*;
(
  input  logic start,
  input  cmd_t cmd,
  input  logic q_full,
  output logic busy,
  output logic push,
  output job_t job
);

  // Accept while the queue has room
  assign busy = q_full;
  assign push = start && !q_full;

  // Decode the action into a job for the back end
  always_comb begin
    job             = '0;
    job.action      = cmd.action;
    job.entry_index = cmd.entry_index;
    job.entry.vs    = cmd.virt_start;
    job.entry.vsz   = cmd.virt_size;
    job.entry.rs    = cmd.raw_start;
    job.entry.rsz   = cmd.raw_size;
    job.addr        = cmd.query_addr;
    job.by_raw      = (cmd.action == ACT_F2V);
    unique case (cmd.action)
      ACT_WRITE: begin
        job.kind = JOB_WRITE;
      end
      ACT_V2F, ACT_V2REL, ACT_F2V, ACT_V2IDX: begin
        job.kind = JOB_LOOKUP;
      end
      default: begin
        job.kind = JOB_NONE;
      end
    endcase
  end

endmodule

// ----- hdl/sxt_fifo.sv -----
module sxt_fifo
  import sxt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  input  logic pop,
  output job_t dout,
  output logic empty,
  output logic full
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_W + 1)'(QDEPTH));
  assign dout  = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// ----- hdl/sxt_back.sv -----
module sxt_back
  import sxt_pkg::*;
#(
  parameter int MAX_SECTIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] section_count,
  input  job_t               q_job,
  input  logic               q_empty,
  output logic               pop,
  output logic               done,
  output res_t               result
);

  // Only entries reachable by entry_index are stored
  localparam int DEPTH = (MAX_SECTIONS < TABLE_CAP) ? MAX_SECTIONS : TABLE_CAP;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_CALC
  } state_t;

  state_t             state;
  job_t               job;
  logic [COUNT_W-1:0] scan_idx;
  logic [COUNT_W-1:0] limit;
  logic               is_last;

  entry_t             mem [DEPTH];
  entry_t             rd_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;

  logic [ADDR_W-1:0]  lo;
  logic [ADDR_W-1:0]  sz;
  logic [ADDR_W:0]    hi;
  logic               hit;
  logic [ADDR_W-1:0]  diff;
  logic [ADDR_W-1:0]  other;
  logic [ADDR_W-1:0]  diff_q;
  logic [ADDR_W-1:0]  other_q;
  logic [VALUE_W-1:0] value_calc;

  // Active count saturates at the table depth
  assign limit   = (section_count > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : section_count;
  assign is_last = ((scan_idx + 1'b1) >= limit);

  assign pop = (state == ST_IDLE) && !q_empty;

  // Table port control
  assign wr_en   = pop && (q_job.kind == JOB_WRITE)
                   && ({1'b0, q_job.entry_index} < COUNT_W'(DEPTH));
  assign wr_addr = q_job.entry_index[AW-1:0];
  assign rd_en   = (state == ST_FETCH);
  assign rd_addr = scan_idx[AW-1:0];

  // Section table, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_job.entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Range check on the fetched entry, end computed one bit wider
  always_comb begin
    lo    = job.by_raw ? rd_data.rs  : rd_data.vs;
    sz    = job.by_raw ? rd_data.rsz : rd_data.vsz;
    other = job.by_raw ? rd_data.vs  : rd_data.rs;
    hi    = {1'b0, lo} + {1'b0, sz};
    hit   = (job.addr >= lo) && ({1'b0, job.addr} < hi);
    diff  = job.addr - lo;
  end

  // Translated value of the winning entry
  always_comb begin
    unique case (job.action)
      ACT_V2F, ACT_F2V: value_calc = {1'b0, diff_q} + {1'b0, other_q};
      ACT_V2REL:        value_calc = {1'b0, diff_q};
      ACT_V2IDX:        value_calc = VALUE_W'(scan_idx[IDX_W-1:0]);
      default:          value_calc = '0;
    endcase
  end

  // Sequencer: take a job, scan the table entry by entry through fetch and check
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            job <= q_job;
            if (q_job.kind == JOB_LOOKUP && limit != '0) begin
              scan_idx <= '0;
              state    <= ST_FETCH;
            end else begin
              done   <= 1'b1;
              result <= '0;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          priority if (hit) begin
            diff_q  <= diff;
            other_q <= other;
            state   <= ST_CALC;
          end else if (is_last) begin
            done   <= 1'b1;
            result <= '0;
            state  <= ST_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            state    <= ST_FETCH;
          end
        end
        ST_CALC: begin
          done                 <= 1'b1;
          result.found         <= 1'b1;
          result.section_index <= scan_idx[IDX_W-1:0];
          result.value         <= value_calc;
          state                <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A miss reports zero index and value
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.section_index == '0 && result.value == '0)
    else $error("miss result not zero");

  // Scan stays below the active count
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> scan_idx < limit)
    else $error("scan beyond active count");

  // A result is only shown on return to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE)
    else $error("result strobe outside idle");

  // Index mode reports the entry index as value
  a_index_value: assert property (@(posedge clk) disable iff (rst)
    done && result.found && job.action == ACT_V2IDX
      |-> result.value == VALUE_W'(result.section_index))
    else $error("index mode value mismatch");

endmodule

// ----- hdl/section_range_translator_top.sv -----
// Section range translator: a table of image sections with address lookups.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. Action write loads one table entry; the lookup actions
// translate query_addr (virtual to file, virtual to section-relative, file
// to virtual, virtual to section index). Unused actions answer a miss.
// Result channel: every command yields one result, shown for one cycle with
// done high, in command order. There is no back-pressure on results.
// Configuration: APB, one register section_count at offset 0; write only
// while the block is idle. pready is tied high.
// Queueing: commands go into a two-entry queue; the back end takes one per
// visit to idle. A write or unused action answers straight from idle. A
// lookup scans the table in order, each entry fetched through the registered
// table read port and then checked; a hit passes through a calc state before
// the answer, a miss answers after the last active entry. busy rises while
// the queue is full.
// Reset (rst, synchronous) empties the queue, idles the back end and clears
// section_count; table contents are undefined until written.
module section_range_translator_top
  import sxt_pkg::*;
#(
  parameter int MAX_SECTIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  output logic        done,
  output res_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               push;
  logic               pop;
  job_t               front_job;
  job_t               q_job;
  logic               q_empty;
  logic               q_full;
  logic [COUNT_W-1:0] section_count;

  // Configuration register, single word at offset 0
  assign pready = 1'b1;
  assign prdata = {{(32 - COUNT_W){1'b0}}, section_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      section_count <= '0;
    end else if (psel && penable && pwrite && pready && paddr == CFG_COUNT_ADDR) begin
      section_count <= pwdata[COUNT_W-1:0];
    end
  end

  sxt_front u_front (
    .start  (start),
    .cmd    (cmd),
    .q_full (q_full),
    .busy   (busy),
    .push   (push),
    .job    (front_job)
  );

  sxt_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_job),
    .pop   (pop),
    .dout  (q_job),
    .empty (q_empty),
    .full  (q_full)
  );

  sxt_back #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .section_count (section_count),
    .q_job         (q_job),
    .q_empty       (q_empty),
    .pop           (pop),
    .done          (done),
    .result        (result)
  );

endmodule

// ----- tb/translation_checker.sv -----
`timescale 1ns / 1ps

// Watches the command, result and register channels of the section range
// translator, keeps its own copy of the section table and the active count,
// and compares each result with the oldest predicted answer.
module translation_checker
  import sxt_pkg::*;
#(
  parameter int         MAX_SECTIONS = 16,
  parameter logic [1:0] COUNT_ADDR   = 2'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  cmd_t        cmd,
  input  logic        done,
  input  res_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          answers_due
);

  // Own copy of the table and the section_count register
  entry_t             sections [TABLE_CAP];
  logic [COUNT_W-1:0] live_count;

  // Predicted answers, oldest first
  res_t awaited_answers [$];
  res_t want;

  // Expected answer to one command, from the table as it stands
  function automatic res_t translate_lookup(input cmd_t c);
    res_t               r;
    int                 active;
    logic               by_raw;
    logic               hit;
    logic [VALUE_W-1:0] addr;
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    r      = '0;
    hit    = 1'b0;
    active = (live_count > MAX_SECTIONS) ? MAX_SECTIONS : int'(live_count);
    by_raw = (c.action == ACT_F2V);
    addr   = {1'b0, c.query_addr};
    if (c.action != ACT_WRITE && c.action <= ACT_V2IDX) begin
      for (int k = 0; k < active; k++) begin
        if (!hit) begin
          // range ends are 33 bits, so they never wrap
          lo = by_raw ? {1'b0, sections[k].rs} : {1'b0, sections[k].vs};
          hi = lo + (by_raw ? sections[k].rsz : sections[k].vsz);
          if (addr >= lo && addr < hi) begin
            hit             = 1'b1;
            r.found         = 1'b1;
            r.section_index = k[IDX_W-1:0];
            case (c.action)
              ACT_V2F:   r.value = addr - sections[k].vs + sections[k].rs;
              ACT_V2REL: r.value = addr - sections[k].vs;
              ACT_F2V:   r.value = addr - sections[k].rs + sections[k].vs;
              default:   r.value = VALUE_W'(k[IDX_W-1:0]);
            endcase
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      live_count = '0;
      mismatches = 0;
      awaited_answers.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready && paddr == COUNT_ADDR) begin
        live_count = pwdata[COUNT_W-1:0];
      end

      // result transaction against the oldest prediction
      if (done) begin
        if (awaited_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result with nothing outstanding: found=%0b idx=%0d value=%h",
                     $realtime, result.found, result.section_index, result.value);
          end
        end else begin
          want = awaited_answers.pop_front();
          if (result.found !== want.found || result.section_index !== want.section_index ||
              result.value !== want.value) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] mismatch: expected found=%0b idx=%0d value=%h,",
                       $realtime, want.found, want.section_index, want.value);
              $display("    got found=%0b idx=%0d value=%h",
                       result.found, result.section_index, result.value);
            end
          end
        end
      end

      // command transaction: predict, then apply any table write
      if (start && !busy) begin
        awaited_answers = {awaited_answers, translate_lookup(cmd)};
        if (cmd.action == ACT_WRITE && cmd.entry_index < MAX_SECTIONS) begin
          sections[cmd.entry_index] = '{vs: cmd.virt_start, vsz: cmd.virt_size,
                                        rs: cmd.raw_start, rsz: cmd.raw_size};
        end
      end
    end
    answers_due = awaited_answers.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import sxt_pkg::*;

  localparam int                  MAX_SECTIONS       = 16;
  localparam logic [1:0]          SECTION_COUNT_ADDR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST    = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST     = 3'd7;
  localparam int                  CYCLE_LIMIT        = 500000;
  localparam int                  PHASE_ITEMS        = 150;
  localparam int                  DRAIN_CYCLES       = 40;
  localparam int                  CALM_PHASE         = 3;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        start   = 1'b0;
  cmd_t        cmd     = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [1:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        busy;
  logic        done;
  res_t        result;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          answers_due;
  int          cycle_count = 0;

  // Section layout as loaded, used to aim queries at real ranges
  entry_t      plan [TABLE_CAP];
  int unsigned live_count = 0;
  int unsigned count_plan [10] = '{16, 31, 1, 8, 17, 0, 3, 12, 16, 2};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  section_range_translator_top #(.MAX_SECTIONS(MAX_SECTIONS)) uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  translation_checker #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .COUNT_ADDR   (SECTION_COUNT_ADDR)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .answers_due (answers_due)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.action      = ACTION_W'($urandom_range(0, 7));
    c.entry_index = IDX_W'($urandom_range(0, TABLE_CAP - 1));
    c.virt_start  = $urandom;
    c.virt_size   = $urandom;
    c.raw_start   = $urandom;
    c.raw_size    = $urandom;
    c.query_addr  = $urandom;
    return c;
  endfunction

  // Mix of scattered, clustered, top-of-space and empty sections
  function automatic entry_t random_entry();
    entry_t e;
    e = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 3))
      0: begin
        // anywhere, any size
      end
      1: begin
        e.vs  = $urandom_range(0, 'h2_0000);
        e.vsz = $urandom_range(1, 'h8000);
        e.rs  = $urandom_range(0, 'h2_0000);
        e.rsz = $urandom_range(1, 'h8000);
      end
      2: begin
        e.vs = 32'hFFFF_FFFF - $urandom_range(0, 'hFFFF);
        e.rs = 32'hFFFF_FFFF - $urandom_range(0, 'hFFFF);
      end
      default: begin
        e.vs = $urandom_range(0, 'h2_0000);
        e.rs = $urandom_range(0, 'h2_0000);
        if ($urandom_range(0, 1)) e.vsz = '0;
        else e.rsz = '0;
      end
    endcase
    return e;
  endfunction

  // Address inside, on the edges of, or just outside one section's range
  function automatic logic [ADDR_W-1:0] aim_addr(input int k, input logic by_raw);
    longint unsigned lo;
    longint unsigned sz;
    longint unsigned span;
    longint unsigned pick;
    longint unsigned space_end;
    space_end = 64'h1_0000_0000;
    lo        = by_raw ? plan[k].rs : plan[k].vs;
    sz        = by_raw ? plan[k].rsz : plan[k].vsz;
    pick      = $urandom;
    if (sz == 0) return $urandom;
    span = (sz < space_end - lo) ? sz : space_end - lo;
    case ($urandom_range(0, 9))
      0:       return ADDR_W'(lo);
      1:       return ADDR_W'(lo + span - 1);
      2:       return ADDR_W'((lo + sz < space_end) ? lo + sz : lo);
      3:       return ADDR_W'((lo > 0) ? lo - 1 : lo);
      default: return ADDR_W'(lo + pick % span);
    endcase
  endfunction

  function automatic int active_entries();
    return (live_count > MAX_SECTIONS) ? MAX_SECTIONS : int'(live_count);
  endfunction

  // Present one transaction and hold it until taken
  task automatic issue(input cmd_t c);
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      cmd   <= random_cmd();
    end
  endtask

  task automatic query(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr);
    cmd_t c;
    c            = random_cmd();
    c.action     = act;
    c.query_addr = addr;
    issue(c);
  endtask

  task automatic load_entry(input logic [IDX_W-1:0] idx, input entry_t e);
    cmd_t c;
    c             = random_cmd();
    c.action      = ACT_WRITE;
    c.entry_index = idx;
    c.virt_start  = e.vs;
    c.virt_size   = e.vsz;
    c.raw_start   = e.rs;
    c.raw_size    = e.rsz;
    plan[idx]     = e;
    issue(c);
  endtask

  // Drop start and wait for the block to drain
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (answers_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write of section_count: setup then access
  task automatic set_count(input int unsigned v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SECTION_COUNT_ADDR;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    live_count = v;
  endtask

  // Mostly lookups aimed at loaded sections, some writes, spares and strays
  task automatic random_item();
    cmd_t   c;
    entry_t e;
    int     roll;
    int     act;
    c    = random_cmd();
    e    = random_entry();
    roll = $urandom_range(0, 99);
    act  = active_entries();
    if (roll < 10) begin
      c.action          = ACT_WRITE;
      c.virt_start      = e.vs;
      c.virt_size       = e.vsz;
      c.raw_start       = e.rs;
      c.raw_size        = e.rsz;
      plan[c.entry_index] = e;
    end else if (roll < 15) begin
      c.action = ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    end else begin
      c.action = ACTION_W'($urandom_range(ACT_V2F, ACT_V2IDX));
      if (roll >= 25 && act > 0) begin
        c.query_addr = aim_addr(int'($urandom_range(0, act - 1)), c.action == ACT_F2V);
      end
    end
    issue(c);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty table: every lookup misses, spare actions answer zero
    set_count(0);
    query(ACT_V2F, $urandom);
    query(ACT_V2REL, $urandom);
    query(ACT_F2V, $urandom);
    query(ACT_V2IDX, $urandom);
    query(ACT_SPARE_FIRST, $urandom);
    query(ACT_SPARE_LAST, $urandom);

    // Overlaps, a range running past the 32-bit top, an empty entry
    load_entry(0, '{vs: 32'h1000, vsz: 32'h2000, rs: 32'h400, rsz: 32'h2000});
    load_entry(1, '{vs: 32'hFFFF_F000, vsz: 32'hFFFF_FFFF,
                    rs: 32'hFFFF_FFFF, rsz: 32'hFFFF_FFFF});
    load_entry(2, '{vs: 32'h0, vsz: 32'h0, rs: 32'h5000, rsz: 32'h0});
    load_entry(3, '{vs: 32'h1800, vsz: 32'h2000, rs: 32'h3000, rsz: 32'h1000});
    load_entry(4, '{vs: 32'h0, vsz: 32'hFFFF_FFFF, rs: 32'hFFFF_FFFF, rsz: 32'h100});
    settle();
    set_count(5);
    query(ACT_V2F, 32'h1000);
    query(ACT_V2F, 32'h2FFF);
    query(ACT_V2REL, 32'h3000);
    query(ACT_V2REL, 32'h3800);
    query(ACT_V2IDX, 32'hFFFF_FFFF);
    query(ACT_V2F, 32'h8000_0000);
    query(ACT_F2V, 32'hFFFF_FFFF);
    query(ACT_F2V, 32'h0);
    query(ACT_F2V, 32'h3FFF);
    query(ACT_V2IDX, 32'h2000);

    // Fill the whole table before any larger count is set
    for (int k = 0; k < TABLE_CAP; k++) load_entry(IDX_W'(k), random_entry());

    // Random phases, each under its own section count
    for (int ph = 0; ph < $size(count_plan); ph++) begin
      settle();
      set_count(count_plan[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph != CALM_PHASE && $urandom_range(0, 99) < 33) pause($urandom_range(1, 4));
        random_item();
      end
    end

    settle();
    if (mismatches == 0 && answers_due == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
